### hw/rtl/bph_pkg.sv
package bph_pkg;

    // Default sizes
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Bin store geometry: one bin per byte value
    localparam int NUM_BINS = 256;
    localparam int BIN_AW   = 8;

    // Fixed widths of the result fields
    localparam int OUT_COUNT_W = 32;
    localparam int OUT_PROB_W  = 17;

    // Command codes
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Input item
    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [7:0] sample_byte;
        logic signed [7:0] bin_index;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [OUT_COUNT_W-1:0] bin_count;
        logic                   bin_seen;
        logic [OUT_COUNT_W-1:0] total_count;
        logic [OUT_PROB_W-1:0]  probability;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture item, issue bin read
        logic incr;      // write back incremented bin, bump total
        logic clear;     // drop all bins and the total
        logic setup;     // latch count and total flags, prime the divider
        logic div_step;  // one restoring division step
    } t_dp_ctl;

endpackage

### hw/rtl/bph_ctrl.sv
module bph_ctrl
    import bph_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_done,
    output t_dp_ctl o_ctl
);

    localparam int SW = $clog2(FRACTION_BITS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INC   = 5'b00010,
        S_SETUP = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [SW-1:0] r_step, n_step;
    logic          take;

    assign take = i_start && (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (take && (i_cmd == CMD_SAMPLE)) begin
                    n_state = S_INC;
                end else if (take && (i_cmd == CMD_READ)) begin
                    n_state = S_SETUP;
                end
            end
            S_INC: begin
                n_state = S_IDLE;
            end
            S_SETUP: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                if (r_step == SW'(FRACTION_BITS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Datapath commands
    always_comb begin
        o_ctl.load     = take && ((i_cmd == CMD_SAMPLE) || (i_cmd == CMD_READ));
        o_ctl.clear    = take && (i_cmd == CMD_CLEAR);
        o_ctl.incr     = (r_state == S_INC);
        o_ctl.setup    = (r_state == S_SETUP);
        o_ctl.div_step = (r_state == S_DIV);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

    // Checks
    a_read_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_cmd == CMD_READ)) |=> o_busy)
        else $error("read transfer did not make the block busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DIV))
        else $error("result strobe without a finished division");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !(o_ctl.load || o_ctl.clear))
        else $error("new item started while busy");

endmodule

### hw/rtl/bph_dpath.sv
module bph_dpath
    import bph_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_ctl   i_ctl,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int CW = COUNT_WIDTH;
    localparam int FW = FRACTION_BITS;
    localparam int EW = (CW > OUT_COUNT_W) ? CW : OUT_COUNT_W;
    localparam int PW = (FW + 1 > OUT_PROB_W) ? FW + 1 : OUT_PROB_W;

    logic [CW-1:0]       mem [NUM_BINS];
    logic [CW-1:0]       r_rdata;
    logic [NUM_BINS-1:0] r_valid;
    logic [BIN_AW-1:0]   r_addr;
    logic [CW-1:0]       r_total;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_rem;
    logic [FW-1:0]       r_quot;
    logic                r_zero;
    logic                r_full;

    logic [BIN_AW-1:0]   rd_addr;
    logic [CW-1:0]       cur;
    logic [CW-1:0]       cur_inc;
    logic [CW:0]         shifted;
    logic [CW:0]         diff;
    logic [FW:0]         prob;
    logic [EW-1:0]       cnt_ext;
    logic [EW-1:0]       tot_ext;
    logic [PW-1:0]       prob_ext;

    // Bin address of the incoming item
    assign rd_addr = (t_cmd'(i_item.cmd) == CMD_SAMPLE) ? $unsigned(i_item.sample_byte)
                                                        : $unsigned(i_item.bin_index);

    // A bin not written since clear reads as zero
    assign cur     = r_valid[r_addr] ? r_rdata : '0;
    assign cur_inc = (cur == '1) ? cur : cur + 1'b1;

    // Bin memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.incr) begin
            mem[r_addr] <= cur_inc;
        end
        if (i_ctl.load) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Valid bits and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_total <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
            r_total <= '0;
        end else if (i_ctl.incr) begin
            r_valid[r_addr] <= 1'b1;
            r_total         <= (r_total == '1) ? r_total : r_total + 1'b1;
        end
    end

    // Restoring division step: remainder stays below the total when the count is below it
    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_total};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_addr <= rd_addr;
        end
        if (i_ctl.setup) begin
            r_cnt  <= cur;
            r_rem  <= cur;
            r_quot <= '0;
            r_zero <= (r_total == '0);
            r_full <= (cur >= r_total);
        end else if (i_ctl.div_step) begin
            if (!diff[CW]) begin
                r_rem  <= diff[CW-1:0];
                r_quot <= {r_quot[FW-2:0], 1'b1};
            end else begin
                r_rem  <= shifted[CW-1:0];
                r_quot <= {r_quot[FW-2:0], 1'b0};
            end
        end
    end

    // Result fields, masked to their widths
    always_comb begin
        if (r_zero) begin
            prob = '0;
        end else if (r_full) begin
            prob = {1'b1, {FW{1'b0}}};
        end else begin
            prob = {1'b0, r_quot};
        end
        cnt_ext  = EW'(r_cnt);
        tot_ext  = EW'(r_total);
        prob_ext = PW'(prob);
        o_result.bin_count   = cnt_ext[OUT_COUNT_W-1:0];
        o_result.bin_seen    = (r_cnt != '0);
        o_result.total_count = tot_ext[OUT_COUNT_W-1:0];
        o_result.probability = prob_ext[OUT_PROB_W-1:0];
    end

endmodule

### hw/rtl/byte_probability_histogram.sv
// Channel  | Ports                      | Transfer
// ---------+----------------------------+-----------------------------------------
// item in  | i_start, i_item, o_busy    | rising edge with i_start high, o_busy low
// result   | o_done, o_result           | rising edge ending the o_done cycle
//
// Sample: bin read, then write-back of the incremented bin.
// Read: bin read, divider setup; the restoring divider retires one quotient
//   bit per cycle, then the result strobe. Clear and the unused code leave o_busy low.
// Reset (synchronous, active low) drops all bins through per-bin valid bits
//   and zeroes the total at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module byte_probability_histogram
    import bph_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_done,
    output t_out_item o_result
);

    t_dp_ctl ctl;

    // Sequencer
    bph_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (t_cmd'(i_item.cmd)),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_ctl   (ctl)
    );

    // Bin store, total and divider
    bph_dpath #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

### dv/byte_probability_histogram_test.sv
`timescale 1ns / 100ps

module byte_probability_histogram_test;
    import bph_pkg::*;

    localparam int CW           = COUNT_WIDTH_DEF;
    localparam int FRAC         = FRACTION_BITS_DEF;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 2 * (FRAC + 3);
    localparam int CYCLE_LIMIT  = 200000;

    // One row of the directed table; want is only used when typed is set
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_busy;
    logic      o_done;
    t_out_item o_result;

    byte_probability_histogram i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Histogram state mirrored by the testbench
    logic [CW-1:0] bin_tally [NUM_BINS];
    logic [CW-1:0] sample_tally;

    t_out_item readout_q [$];
    t_stim_row directed_rows [$];
    t_out_item oldest_readout;
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[byte_probability_histogram] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [CW-1:0] sat_incr(input logic [CW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Apply one accepted item to the mirrored histogram; reads give a readout
    task automatic tally_item(input t_in_item it, output bit has_readout,
                              output t_out_item readout);
        logic [BIN_AW-1:0]  idx;
        logic [CW-1:0]      cnt;
        logic [CW+FRAC-1:0] scaled;
        has_readout = 1'b0;
        readout     = '0;
        case (t_cmd'(it.cmd))
            CMD_SAMPLE: begin
                idx = it.sample_byte;
                bin_tally[idx] = sat_incr(bin_tally[idx]);
                sample_tally   = sat_incr(sample_tally);
            end
            CMD_READ: begin
                idx = it.bin_index;
                cnt = bin_tally[idx];
                has_readout          = 1'b1;
                readout.bin_count    = cnt[OUT_COUNT_W-1:0];
                readout.bin_seen     = (cnt != '0);
                readout.total_count  = sample_tally[OUT_COUNT_W-1:0];
                if (sample_tally == '0) begin
                    readout.probability = '0;
                end else if (cnt >= sample_tally) begin
                    readout.probability = OUT_PROB_W'(1) << FRAC;
                end else begin
                    scaled = {cnt, {FRAC{1'b0}}};
                    scaled = scaled / sample_tally;
                    readout.probability = scaled[OUT_PROB_W-1:0];
                end
            end
            CMD_CLEAR: begin
                for (int b = 0; b < NUM_BINS; b++)
                    bin_tally[b] = '0;
                sample_tally = '0;
            end
            default: ;
        endcase
    endtask

    // Hold one item until the block takes it, then queue what it should return
    task automatic send_item(input t_in_item it, input bit may_idle, input bit typed,
                             input t_out_item want);
        bit        accepted;
        bit        has_readout;
        t_out_item readout;
        while (may_idle && $urandom_range(0, 99) < 32) begin
            i_start <= 1'b0;
            i_item  <= t_in_item'(18'($urandom));
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge i_clk);
            accepted = !o_busy;
            @(posedge i_clk);
        end
        tally_item(it, has_readout, readout);
        if (has_readout)
            readout_q.push_back(typed ? want : readout);
    endtask

    task automatic add_row(input t_cmd op, input logic signed [7:0] sb,
                           input logic signed [7:0] idx, input bit typed,
                           input logic [31:0] cnt, input logic seen,
                           input logic [31:0] tot, input logic [16:0] prob);
        t_stim_row row;
        row.item.cmd         = op;
        row.item.sample_byte = sb;
        row.item.bin_index   = idx;
        row.typed            = typed;
        row.want.bin_count   = cnt;
        row.want.bin_seen    = seen;
        row.want.total_count = tot;
        row.want.probability = prob;
        directed_rows.push_back(row);
    endtask

    // Result checker: the receiver never stalls, so every strobe is a transfer
    always @(negedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (readout_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                oldest_readout = readout_q.pop_front();
                if (o_result.bin_count !== oldest_readout.bin_count)
                    report_mismatch($sformatf("bin_count got %0d want %0d",
                        o_result.bin_count, oldest_readout.bin_count));
                if (o_result.bin_seen !== oldest_readout.bin_seen)
                    report_mismatch($sformatf("bin_seen got %0d want %0d",
                        o_result.bin_seen, oldest_readout.bin_seen));
                if (o_result.total_count !== oldest_readout.total_count)
                    report_mismatch($sformatf("total_count got %0d want %0d",
                        o_result.total_count, oldest_readout.total_count));
                if (o_result.probability !== oldest_readout.probability)
                    report_mismatch($sformatf("probability got %0d want %0d",
                        o_result.probability, oldest_readout.probability));
            end
        end
    end

    initial begin : stimulus
        t_in_item          it;
        logic [BIN_AW-1:0] hot_vals [4];
        int                roll;
        int                sent;

        for (int b = 0; b < NUM_BINS; b++)
            bin_tally[b] = '0;
        sample_tally = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, extremes, single-value stream, clear, unused code
        add_row(CMD_READ,   -8'sd128, -8'sd128, 1, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,    8'sd127, 1, 0, 0, 0, 0);
        add_row(CMD_NONE,    8'sd127, -8'sd128, 0, 0, 0, 0, 0);
        add_row(CMD_SAMPLE,  8'sd127, -8'sd128, 0, 0, 0, 0, 0);
        add_row(CMD_READ,   -8'sd128,  8'sd127, 1, 1, 1, 1, 17'd65536);
        add_row(CMD_READ,    8'sd127, -8'sd128, 1, 0, 0, 1, 0);
        add_row(CMD_SAMPLE, -8'sd128,  8'sd127, 0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,   -8'sd128, 1, 1, 1, 2, 17'd32768);
        add_row(CMD_SAMPLE,  8'sd0,    8'sd0,   0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,    8'sd0,   0, 0, 0, 0, 0);
        add_row(CMD_SAMPLE,  8'sd127,  8'sd0,   0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,    8'sd127, 0, 0, 0, 0, 0);
        add_row(CMD_CLEAR,  -8'sd1,   -8'sd1,   0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,    8'sd127, 1, 0, 0, 0, 0);
        add_row(CMD_SAMPLE, -8'sd1,    8'sd0,   0, 0, 0, 0, 0);
        add_row(CMD_SAMPLE, -8'sd1,    8'sd0,   0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,   -8'sd1,   1, 2, 1, 2, 17'd65536);
        add_row(CMD_SAMPLE,  8'sd85,   8'sd0,   0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,    8'sd85,  0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,   -8'sd86,  0, 0, 0, 0, 0);
        add_row(CMD_NONE,   -8'sd1,   -8'sd1,   0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,   -8'sd1,   0, 0, 0, 0, 0);
        add_row(CMD_CLEAR,   8'sd0,    8'sd0,   0, 0, 0, 0, 0);
        add_row(CMD_SAMPLE, -8'sd128,  8'sd0,   0, 0, 0, 0, 0);
        add_row(CMD_READ,    8'sd0,   -8'sd128, 1, 1, 1, 1, 17'd65536);

        @(posedge i_clk);
        foreach (directed_rows[r])
            send_item(directed_rows[r].item, 1'b1, directed_rows[r].typed,
                      directed_rows[r].want);

        // Random: skewed sample stream with reads mixed in, rare clears and unused codes
        for (int h = 0; h < 4; h++)
            hot_vals[h] = BIN_AW'($urandom);
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            it   = t_in_item'(18'($urandom));
            roll = $urandom_range(0, 999);
            if (roll < 700) begin
                it.cmd = CMD_SAMPLE;
                if ($urandom_range(0, 99) < 60)
                    it.sample_byte = hot_vals[$urandom_range(0, 3)];
            end else if (roll < 950) begin
                it.cmd = CMD_READ;
                roll   = $urandom_range(0, 99);
                if (roll < 50)
                    it.bin_index = hot_vals[$urandom_range(0, 3)];
                else if (roll < 65)
                    it.bin_index = ($urandom_range(0, 1) != 0) ? 8'sh80 : 8'sh7f;
            end else if (roll < 957) begin
                it.cmd = CMD_CLEAR;
            end else begin
                it.cmd = CMD_NONE;
            end

            // a long stretch back to back in the middle of the run
            send_item(it, !(sent >= 400 && sent < 600), 1'b0, '0);
            if (t_cmd'(it.cmd) != CMD_NONE)
                sent++;
            if (t_cmd'(it.cmd) == CMD_CLEAR) begin
                for (int h = 0; h < 4; h++)
                    hot_vals[h] = BIN_AW'($urandom);
            end
        end
        i_start <= 1'b0;

        // Drain outstanding reads, then give the block time for stray results
        while (readout_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && readout_q.size() == 0) begin
            $display("[byte_probability_histogram] OK");
        end else begin
            $display("[byte_probability_histogram] ERROR");
        end
        $finish;
    end

endmodule
